>>> rtl/dtd_pkg.sv
// Shared widths, constants, types and the month offset table of the date-time difference unit.
package dtd_pkg;

    // Field widths of the ports
    localparam int YEAR_W   = 14;
    localparam int MONTH_W  = 4;
    localparam int DAY_W    = 5;
    localparam int HOUR_W   = 5;
    localparam int MIN_W    = 6;
    localparam int SEC_W    = 6;
    localparam int HOURS_W  = 27;

    // Largest year accepted as valid
    localparam int MAX_YEAR = 9999;

    // Internal widths
    localparam int Q_W      = YEAR_W - 6;   // quotient of a year count by 100
    localparam int CENT_R_W = 7;            // remainder of a year count by 100
    localparam int DAYS_W   = 22;           // day count since year 1
    localparam int MOFF_W   = 9;            // day offset within one year
    localparam int MLEN_W   = 5;            // month length
    localparam int MS_W     = 12;           // minute and second part of an hour
    localparam int DMS_W    = MS_W + 2;     // signed difference of two such parts
    localparam int DH_W     = HOURS_W + 1;  // signed difference of two hour counts

    // Calendar constants
    localparam int CENTURY      = 100;
    localparam int DAYS_IN_YEAR = 365;
    localparam int HOURS_IN_DAY = 24;
    localparam int SEC_PER_MIN  = 60;
    localparam int SEC_PER_HOUR = 3600;
    localparam int MAX_HOUR     = 23;
    localparam int MAX_MINUTE   = 59;
    localparam int MAX_SECOND   = 59;
    localparam int LAST_MONTH   = 12;
    localparam int FEBRUARY     = 2;
    localparam int APRIL        = 4;
    localparam int JUNE         = 6;
    localparam int SEPTEMBER    = 9;
    localparam int NOVEMBER     = 11;

    // Reciprocal multipliers: x / 100 for x below 2**14, x / 60 for x below 3600
    localparam int DIV100_MUL   = 5243;
    localparam int DIV100_MUL_W = 13;
    localparam int DIV100_SH    = 19;
    localparam int DIV60_MUL    = 2185;
    localparam int DIV60_MUL_W  = 12;
    localparam int DIV60_SH     = 17;

    // Stage enables of the per-date conversion pipeline
    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
    } pipe_en_t;

    // Result of converting one date-time
    typedef struct packed {
        logic [HOURS_W-1:0] hours;
        logic [MS_W-1:0]    ms;
        logic               bad;
    } conv_out_t;

    // Days in the common year before the first of a month (1 to 12)
    function automatic logic [MOFF_W-1:0] days_before_month(input logic [MONTH_W-1:0] month);
        logic [MOFF_W-1:0] d;
        unique case (month)
            4'd1:    d = 9'd0;
            4'd2:    d = 9'd31;
            4'd3:    d = 9'd59;
            4'd4:    d = 9'd90;
            4'd5:    d = 9'd120;
            4'd6:    d = 9'd151;
            4'd7:    d = 9'd181;
            4'd8:    d = 9'd212;
            4'd9:    d = 9'd243;
            4'd10:   d = 9'd273;
            4'd11:   d = 9'd304;
            4'd12:   d = 9'd334;
            default: d = 9'd0;
        endcase
        return d;
    endfunction

endpackage

>>> rtl/datetime_difference_unit.sv
// Top level of the date-time difference unit: input register, two converters, difference, split.
//
// Usage: present two Gregorian date-times (year, month, day, hour, minute,
// second) on the input channel with in_valid; a transfer happens when in_valid
// and in_ready are both high. Each transfer yields exactly one result on the
// output channel: the absolute difference as whole hours (not wrapped at 24),
// minutes and seconds, and invalid when any field of either date-time is out
// of range. The result values are computed even when invalid is set.
// An input transfer reaches out_valid through the input register, three
// conversion stages, the difference stage and the output register.
// Throughput: one item per cycle while out_ready is high, set by the six
// pipeline registers, each of which takes a new item whenever it is empty or
// its successor takes its item.
// Stall: when out_ready is low the output register holds its result and the
// stages behind it keep filling until each holds an item; in_ready then falls.
// Reset: clears every stage valid bit; with every stage empty, the block
// accepts an item once reset is released.
module datetime_difference_unit
    import dtd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [YEAR_W-1:0]  a_year,
    input  logic [MONTH_W-1:0] a_month,
    input  logic [DAY_W-1:0]   a_day,
    input  logic [HOUR_W-1:0]  a_hour,
    input  logic [MIN_W-1:0]   a_minute,
    input  logic [SEC_W-1:0]   a_second,
    input  logic [YEAR_W-1:0]  b_year,
    input  logic [MONTH_W-1:0] b_month,
    input  logic [DAY_W-1:0]   b_day,
    input  logic [HOUR_W-1:0]  b_hour,
    input  logic [MIN_W-1:0]   b_minute,
    input  logic [SEC_W-1:0]   b_second,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [HOURS_W-1:0] diff_hours,
    output logic [MIN_W-1:0]   diff_minutes,
    output logic [SEC_W-1:0]   diff_seconds,
    output logic               invalid
);

    localparam int STAGES  = 6;
    localparam int MPROD_W = MS_W + DIV60_MUL_W;

    // Stage valid bits and load enables; stage 0 is the input register
    logic [STAGES-1:0] vld_reg, vld_next;
    logic [STAGES-1:0] ld;
    pipe_en_t          conv_en;

    // Input register
    logic [YEAR_W-1:0]  a_year_reg,   b_year_reg;
    logic [MONTH_W-1:0] a_month_reg,  b_month_reg;
    logic [DAY_W-1:0]   a_day_reg,    b_day_reg;
    logic [HOUR_W-1:0]  a_hour_reg,   b_hour_reg;
    logic [MIN_W-1:0]   a_minute_reg, b_minute_reg;
    logic [SEC_W-1:0]   a_second_reg, b_second_reg;

    // Converter results
    conv_out_t res_a, res_b;

    // Difference stage
    logic signed [DH_W-1:0]  dh, dh_adj;
    logic signed [DMS_W-1:0] dms, dms_adj;
    logic [MS_W-1:0]         ms_adj;
    logic                    neg;
    logic [HOURS_W-1:0]      hrs_s4_reg, hrs_s4_next;
    logic [MS_W-1:0]         rem_s4_reg, rem_s4_next;
    logic                    bad_s4_reg, bad_s4_next;

    // Split stage
    logic [MPROD_W-1:0] min_prod;
    logic [MIN_W-1:0]   min_next;
    logic [MS_W-1:0]    sec_full;
    logic [HOURS_W-1:0] hrs_out_reg;
    logic [MIN_W-1:0]   min_out_reg;
    logic [SEC_W-1:0]   sec_out_reg;
    logic               bad_out_reg;

    // Load a stage when it is empty or its item moves on
    always_comb
    begin
        ld[STAGES-1] = !vld_reg[STAGES-1] || out_ready;
        for (int i = STAGES - 2; i >= 0; i--)
        begin
            ld[i] = !vld_reg[i] || ld[i+1];
        end
    end

    always_comb
    begin
        vld_next[0] = ld[0] ? in_valid : vld_reg[0];
        for (int i = 1; i < STAGES; i++)
        begin
            vld_next[i] = ld[i] ? vld_reg[i-1] : vld_reg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    assign in_ready   = ld[0];
    assign out_valid  = vld_reg[STAGES-1];
    assign conv_en.s1 = ld[1];
    assign conv_en.s2 = ld[2];
    assign conv_en.s3 = ld[3];

    // Capture the input transfer
    always_ff @(posedge clk)
    begin
        if (ld[0])
        begin
            a_year_reg   <= a_year;
            a_month_reg  <= a_month;
            a_day_reg    <= a_day;
            a_hour_reg   <= a_hour;
            a_minute_reg <= a_minute;
            a_second_reg <= a_second;
            b_year_reg   <= b_year;
            b_month_reg  <= b_month;
            b_day_reg    <= b_day;
            b_hour_reg   <= b_hour;
            b_minute_reg <= b_minute;
            b_second_reg <= b_second;
        end
    end

    dtd_conv u_conv_a (
        .clk    (clk),
        .en     (conv_en),
        .year   (a_year_reg),
        .month  (a_month_reg),
        .day    (a_day_reg),
        .hour   (a_hour_reg),
        .minute (a_minute_reg),
        .second (a_second_reg),
        .res    (res_a)
    );

    dtd_conv u_conv_b (
        .clk    (clk),
        .en     (conv_en),
        .year   (b_year_reg),
        .month  (b_month_reg),
        .day    (b_day_reg),
        .hour   (b_hour_reg),
        .minute (b_minute_reg),
        .second (b_second_reg),
        .res    (res_b)
    );

    // Subtract, bring the seconds part into 0..3599 by moving whole hours
    assign dh  = $signed({1'b0, res_a.hours}) - $signed({1'b0, res_b.hours});
    assign dms = $signed(DMS_W'(res_a.ms)) - $signed(DMS_W'(res_b.ms));

    always_comb
    begin
        priority if (dms >= $signed(DMS_W'(SEC_PER_HOUR)))
        begin
            dms_adj = dms - $signed(DMS_W'(SEC_PER_HOUR));
            dh_adj  = dh + $signed(DH_W'(1));
        end
        else if (dms >= $signed(DMS_W'(0)))
        begin
            dms_adj = dms;
            dh_adj  = dh;
        end
        else if (dms >= -$signed(DMS_W'(SEC_PER_HOUR)))
        begin
            dms_adj = dms + $signed(DMS_W'(SEC_PER_HOUR));
            dh_adj  = dh - $signed(DH_W'(1));
        end
        else
        begin
            dms_adj = dms + $signed(DMS_W'(2 * SEC_PER_HOUR));
            dh_adj  = dh - $signed(DH_W'(2));
        end
    end

    // Take the magnitude: a negative count borrows one hour unless the part is zero
    assign ms_adj = dms_adj[MS_W-1:0];
    assign neg    = dh_adj[DH_W-1];

    always_comb
    begin
        if (!neg)
        begin
            hrs_s4_next = dh_adj[HOURS_W-1:0];
            rem_s4_next = ms_adj;
        end
        else if (ms_adj == '0)
        begin
            hrs_s4_next = HOURS_W'(-dh_adj);
            rem_s4_next = '0;
        end
        else
        begin
            hrs_s4_next = HOURS_W'(~dh_adj);
            rem_s4_next = MS_W'(SEC_PER_HOUR) - ms_adj;
        end
    end

    assign bad_s4_next = res_a.bad | res_b.bad;

    always_ff @(posedge clk)
    begin
        if (ld[4])
        begin
            hrs_s4_reg <= hrs_s4_next;
            rem_s4_reg <= rem_s4_next;
            bad_s4_reg <= bad_s4_next;
        end
    end

    // Split the seconds within the hour into minutes and seconds
    assign min_prod = MPROD_W'(rem_s4_reg) * MPROD_W'(DIV60_MUL);
    assign min_next = min_prod[DIV60_SH +: MIN_W];
    assign sec_full = rem_s4_reg - MS_W'(min_next) * MS_W'(SEC_PER_MIN);

    always_ff @(posedge clk)
    begin
        if (ld[5])
        begin
            hrs_out_reg <= hrs_s4_reg;
            min_out_reg <= min_next;
            sec_out_reg <= sec_full[SEC_W-1:0];
            bad_out_reg <= bad_s4_reg;
        end
    end

    assign diff_hours   = hrs_out_reg;
    assign diff_minutes = min_out_reg;
    assign diff_seconds = sec_out_reg;
    assign invalid      = bad_out_reg;

endmodule

>>> rtl/dtd_conv.sv
// Three-stage conversion of one date-time into hours since year 1 and seconds within the hour.
module dtd_conv
    import dtd_pkg::*;
(
    input  logic               clk,
    input  pipe_en_t           en,
    input  logic [YEAR_W-1:0]  year,
    input  logic [MONTH_W-1:0] month,
    input  logic [DAY_W-1:0]   day,
    input  logic [HOUR_W-1:0]  hour,
    input  logic [MIN_W-1:0]   minute,
    input  logic [SEC_W-1:0]   second,
    output conv_out_t          res
);

    localparam int PROD_W = YEAR_W + DIV100_MUL_W;

    // Stage 1 signals
    logic [YEAR_W-1:0]  y_cl;
    logic [MONTH_W-1:0] mo_cl;
    logic               bad1;
    logic [PROD_W-1:0]  q_prod;

    logic [YEAR_W-1:0]  n_s1_reg,     n_s1_next;
    logic [Q_W-1:0]     q_s1_reg,     q_s1_next;
    logic [MONTH_W-1:0] mo_s1_reg;
    logic [DAY_W-1:0]   day_s1_reg;
    logic [HOUR_W-1:0]  hour_s1_reg;
    logic [MS_W-1:0]    ms_s1_reg,    ms_s1_next;
    logic               bad_s1_reg;

    // Stage 2 signals
    logic [YEAR_W-1:0]   r_full;
    logic [CENT_R_W-1:0] r_cent;
    logic                cent_end;
    logic [1:0]          y_lo;
    logic [1:0]          qy_lo;
    logic                leap;
    logic [MLEN_W-1:0]   mlen;
    logic                day_bad;

    logic [DAYS_W-1:0]  base_s2_reg,  base_s2_next;
    logic [MOFF_W-1:0]  moff_s2_reg,  moff_s2_next;
    logic [HOUR_W-1:0]  hour_s2_reg;
    logic [MS_W-1:0]    ms_s2_reg;
    logic               bad_s2_reg,   bad_s2_next;

    // Stage 3 signals
    logic [DAYS_W-1:0]  days;
    conv_out_t          res_reg,      res_next;

    // Clamp year and month, check the time of day, divide the year count by 100
    always_comb
    begin
        bad1  = 1'b0;
        y_cl  = year;
        mo_cl = month;
        if (year == '0)
        begin
            y_cl = YEAR_W'(1);
            bad1 = 1'b1;
        end
        else if (32'(year) > MAX_YEAR)
        begin
            y_cl = YEAR_W'(MAX_YEAR);
            bad1 = 1'b1;
        end
        if (month == '0)
        begin
            mo_cl = MONTH_W'(1);
            bad1  = 1'b1;
        end
        else if (month > MONTH_W'(LAST_MONTH))
        begin
            mo_cl = MONTH_W'(LAST_MONTH);
            bad1  = 1'b1;
        end
        if (hour > HOUR_W'(MAX_HOUR) || minute > MIN_W'(MAX_MINUTE)
            || second > SEC_W'(MAX_SECOND))
        begin
            bad1 = 1'b1;
        end
    end

    assign n_s1_next  = y_cl - YEAR_W'(1);
    assign q_prod     = PROD_W'(n_s1_next) * PROD_W'(DIV100_MUL);
    assign q_s1_next  = q_prod[DIV100_SH +: Q_W];
    assign ms_s1_next = MS_W'(minute) * MS_W'(SEC_PER_MIN) + MS_W'(second);

    always_ff @(posedge clk)
    begin
        if (en.s1)
        begin
            n_s1_reg    <= n_s1_next;
            q_s1_reg    <= q_s1_next;
            mo_s1_reg   <= mo_cl;
            day_s1_reg  <= day;
            hour_s1_reg <= hour;
            ms_s1_reg   <= ms_s1_next;
            bad_s1_reg  <= bad1;
        end
    end

    // Leap rule: year = count + 1, a century year when the count ends in 99
    assign r_full   = n_s1_reg - YEAR_W'(YEAR_W'(q_s1_reg) * YEAR_W'(CENTURY));
    assign r_cent   = r_full[CENT_R_W-1:0];
    assign cent_end = (r_cent == CENT_R_W'(CENTURY - 1));
    assign y_lo     = n_s1_reg[1:0] + 2'd1;
    assign qy_lo    = q_s1_reg[1:0] + 2'd1;
    assign leap     = cent_end ? (qy_lo == 2'd0) : (y_lo == 2'd0);

    // Length of the month for the day check
    always_comb
    begin
        if (mo_s1_reg == MONTH_W'(APRIL) || mo_s1_reg == MONTH_W'(JUNE)
            || mo_s1_reg == MONTH_W'(SEPTEMBER) || mo_s1_reg == MONTH_W'(NOVEMBER))
        begin
            mlen = MLEN_W'(30);
        end
        else if (mo_s1_reg == MONTH_W'(FEBRUARY))
        begin
            mlen = leap ? MLEN_W'(29) : MLEN_W'(28);
        end
        else
        begin
            mlen = MLEN_W'(31);
        end
    end

    assign day_bad = (day_s1_reg == '0) || (MLEN_W'(day_s1_reg) > mlen);

    // Days of the whole years before, and the offset within the year
    assign base_s2_next = DAYS_W'(n_s1_reg) * DAYS_W'(DAYS_IN_YEAR)
                        + DAYS_W'(n_s1_reg >> 2)
                        - DAYS_W'(q_s1_reg)
                        + DAYS_W'(q_s1_reg >> 2);
    assign moff_s2_next = days_before_month(mo_s1_reg)
                        + MOFF_W'(leap && (mo_s1_reg > MONTH_W'(FEBRUARY)))
                        + MOFF_W'(day_s1_reg);
    assign bad_s2_next  = bad_s1_reg | day_bad;

    always_ff @(posedge clk)
    begin
        if (en.s2)
        begin
            base_s2_reg <= base_s2_next;
            moff_s2_reg <= moff_s2_next;
            hour_s2_reg <= hour_s1_reg;
            ms_s2_reg   <= ms_s1_reg;
            bad_s2_reg  <= bad_s2_next;
        end
    end

    // Total hours since year 1
    assign days           = base_s2_reg + DAYS_W'(moff_s2_reg);
    assign res_next.hours = HOURS_W'(days) * HOURS_W'(HOURS_IN_DAY) + HOURS_W'(hour_s2_reg);
    assign res_next.ms    = ms_s2_reg;
    assign res_next.bad   = bad_s2_reg;

    always_ff @(posedge clk)
    begin
        if (en.s3)
        begin
            res_reg <= res_next;
        end
    end

    assign res = res_reg;

endmodule
